// ===== design/mprq_pkg.sv =====
// Package for the min-priority request queue.
// Holds the item types, operation and status codes, and fixed field widths.
// No dependencies.
`default_nettype none

package mprq_pkg;

    // Fixed field widths of an item.
    localparam int PRIO_W = 16;
    localparam int KIND_W = 2;
    localparam int TAG_W  = 16;
    localparam int OCC_W  = 8;

    // Operation codes.
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_POP    = 1'b1;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_INSERTED = 2'd0,
        ST_FULL     = 2'd1,
        ST_POPPED   = 2'd2,
        ST_EMPTY    = 2'd3
    } t_status;

    // Request kinds.
    typedef enum logic [1:0] {
        KIND_CREATE = 2'd0,
        KIND_STOP   = 2'd1,
        KIND_DELETE = 2'd2,
        KIND_LIST   = 2'd3
    } t_kind;

    // Input item.
    typedef struct packed {
        logic                     operation;
        logic signed [PRIO_W-1:0] priority_req;
        t_kind                    request_kind;
        logic        [TAG_W-1:0]  name_tag;
    } t_in_item;

    // Result item.
    typedef struct packed {
        t_status                  status;
        logic signed [PRIO_W-1:0] out_priority;
        t_kind                    out_kind;
        logic        [TAG_W-1:0]  out_name_tag;
        logic        [OCC_W-1:0]  occupancy;
    } t_out_item;

endpackage

`default_nettype wire

// ===== design/min_priority_request_queue.sv =====
// Min-priority request queue, top level: sequencer, entry store, compare unit.
// Depends on mprq_pkg, mprq_store and mprq_min_unit.
//
// On an insert or a pop on an empty queue, busy stays low and the result
// strobe o_valid rises in the next cycle. A pop on a queue of N entries reads
// every entry once through the single store read port and the shared compare
// unit, then shifts the entries behind the winner down one place, one entry
// per cycle. Busy is high for the whole pop. Each result is shown for exactly
// one cycle with o_valid high and cannot be held off by the receiver; a new
// item may be started in that cycle.
`default_nettype none

module min_priority_request_queue #(
    parameter int DEPTH    = 128,
    parameter int TAG_BITS = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire mprq_pkg::t_in_item i_item,
    output logic                    o_valid,
    output mprq_pkg::t_out_item     o_result
);
    import mprq_pkg::*;

    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int ENTRY_W = PRIO_W + KIND_W + TAG_BITS;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SCAN_END,
        S_LOAD,
        S_SHIFT
    } t_state;

    t_state              r_state;
    logic [CNT_W-1:0]    r_count;
    logic [CNT_W-1:0]    r_idx;
    logic                r_rd_vld;
    logic [ADDR_W-1:0]   r_rd_idx;
    logic                r_valid;
    t_out_item           r_result;
    logic                n_valid;
    t_out_item           n_result;

    logic                w_accept;
    logic                w_pop_done;
    logic                w_rd_en;
    logic                w_wr_en;
    logic [ADDR_W-1:0]   w_wr_addr;
    logic [ENTRY_W-1:0]  w_wr_data;
    logic [ENTRY_W-1:0]  w_rd_data;
    logic [ENTRY_W-1:0]  w_best_entry;
    logic [ADDR_W-1:0]   w_best_idx;
    logic [ENTRY_W-1:0]  w_new_entry;
    logic [CNT_W-1:0]    w_idx_inc;
    logic                w_full;
    logic                w_empty;
    logic [CNT_W+OCC_W-1:0]    w_occ_ext;
    logic [CNT_W+OCC_W-1:0]    w_occ_dec_ext;
    logic [TAG_BITS+TAG_W-1:0] w_tag_in_ext;
    logic [TAG_BITS+TAG_W-1:0] w_tag_out_ext;

    assign w_accept  = start && !busy;
    assign busy      = (r_state != S_IDLE);
    assign o_valid   = r_valid;
    assign o_result  = r_result;
    assign w_idx_inc = r_idx + CNT_W'(1);
    assign w_full    = (r_count == CNT_W'(DEPTH));
    assign w_empty   = (r_count == '0);

    // Tag width adaption in both directions, and occupancy modulo 256.
    assign w_tag_in_ext  = {{TAG_BITS{1'b0}}, i_item.name_tag};
    assign w_tag_out_ext = {{TAG_W{1'b0}}, w_best_entry[TAG_BITS-1:0]};
    assign w_occ_ext     = {{OCC_W{1'b0}}, r_count};
    assign w_occ_dec_ext = {{OCC_W{1'b0}}, r_count - CNT_W'(1)};

    // New entry layout: priority, kind, tag.
    assign w_new_entry = {i_item.priority_req, i_item.request_kind,
                          w_tag_in_ext[TAG_BITS-1:0]};

    // Reads are issued while the index is below the entry count.
    assign w_rd_en = ((r_state == S_SCAN) || (r_state == S_SHIFT)) && (r_idx < r_count);

    // The gap is closed once no read is pending or in flight.
    assign w_pop_done = (r_state == S_SHIFT) && !w_rd_en && !r_rd_vld;

    // Store write: append on insert, or move an entry down during the shift.
    always_comb begin
        w_wr_en   = 1'b0;
        w_wr_addr = r_count[ADDR_W-1:0];
        w_wr_data = w_new_entry;
        if (w_accept && (i_item.operation == OP_INSERT) && !w_full) begin
            w_wr_en = 1'b1;
        end else if ((r_state == S_SHIFT) && r_rd_vld) begin
            w_wr_en   = 1'b1;
            w_wr_addr = r_rd_idx - ADDR_W'(1);
            w_wr_data = w_rd_data;
        end
    end

    mprq_store #(
        .DEPTH  (DEPTH),
        .WIDTH  (ENTRY_W),
        .ADDR_W (ADDR_W)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (r_idx[ADDR_W-1:0]),
        .o_rd_data (w_rd_data)
    );

    mprq_min_unit #(
        .WIDTH  (ENTRY_W),
        .ADDR_W (ADDR_W)
    ) u_min (
        .i_clk        (i_clk),
        .i_vld        (r_rd_vld && ((r_state == S_SCAN) || (r_state == S_SCAN_END))),
        .i_first      (r_rd_idx == '0),
        .i_data       (w_rd_data),
        .i_idx        (r_rd_idx),
        .o_best_entry (w_best_entry),
        .o_best_idx   (w_best_idx)
    );

    // Next result: the answer to an insert or an empty pop at accept, or the popped entry at the end.
    always_comb begin
        n_valid  = 1'b0;
        n_result = r_result;
        if (w_accept && ((i_item.operation == OP_INSERT) || w_empty)) begin
            n_valid  = 1'b1;
            n_result = '0;
            if (i_item.operation == OP_POP) begin
                n_result.status    = ST_EMPTY;
                n_result.occupancy = w_occ_ext[OCC_W-1:0];
            end else if (w_full) begin
                // Insert refused when full.
                n_result.status    = ST_FULL;
                n_result.occupancy = w_occ_ext[OCC_W-1:0];
            end else begin
                n_result.status    = ST_INSERTED;
                n_result.occupancy = OCC_W'(w_occ_ext + (CNT_W+OCC_W)'(1));
            end
        end else if (w_pop_done) begin
            n_valid               = 1'b1;
            n_result.status       = ST_POPPED;
            n_result.out_priority = $signed(w_best_entry[ENTRY_W-1 -: PRIO_W]);
            n_result.out_kind     = t_kind'(w_best_entry[TAG_BITS +: KIND_W]);
            n_result.out_name_tag = w_tag_out_ext[TAG_W-1:0];
            n_result.occupancy    = w_occ_dec_ext[OCC_W-1:0];
        end
    end

    // Sequencer with registered result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_idx    <= '0;
            r_rd_vld <= 1'b0;
            r_rd_idx <= '0;
            r_valid  <= 1'b0;
            r_result <= '0;
        end else begin
            r_valid  <= n_valid;
            r_result <= n_result;
            r_rd_vld <= w_rd_en;
            r_rd_idx <= r_idx[ADDR_W-1:0];
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        if (i_item.operation == OP_INSERT) begin
                            // Insert finishes at once; the count grows unless full.
                            if (!w_full) begin
                                r_count <= r_count + CNT_W'(1);
                            end
                        end else if (!w_empty) begin
                            r_idx   <= '0;
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    // One read per cycle; the last one is issued at count - 1.
                    r_idx <= w_idx_inc;
                    if (w_idx_inc == r_count) begin
                        r_state <= S_SCAN_END;
                    end
                end
                S_SCAN_END: begin
                    // The last entry is compared at the end of this cycle.
                    r_state <= S_LOAD;
                end
                S_LOAD: begin
                    r_idx   <= CNT_W'(w_best_idx) + CNT_W'(1);
                    r_state <= S_SHIFT;
                end
                S_SHIFT: begin
                    if (w_rd_en) begin
                        r_idx <= w_idx_inc;
                    end else if (!r_rd_vld) begin
                        // Gap closed: the popped entry is delivered.
                        r_count <= r_count - CNT_W'(1);
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== design/mprq_store.sv =====
// Entry store of the request queue: one write port, one read port.
// Read data is registered. Depends on nothing else.
`default_nettype none

module mprq_store #(
    parameter int DEPTH  = 128,
    parameter int WIDTH  = 34,
    parameter int ADDR_W = 7
) (
    input  wire logic              i_clk,
    input  wire logic              i_wr_en,
    input  wire logic [ADDR_W-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]  i_wr_data,
    input  wire logic              i_rd_en,
    input  wire logic [ADDR_W-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== design/mprq_min_unit.sv =====
// Shared compare unit: keeps the entry with the smallest priority seen so far.
// Uses the field widths from mprq_pkg.
`default_nettype none

module mprq_min_unit #(
    parameter int WIDTH  = 34,
    parameter int ADDR_W = 7
) (
    input  wire logic              i_clk,
    input  wire logic              i_vld,
    input  wire logic              i_first,
    input  wire logic [WIDTH-1:0]  i_data,
    input  wire logic [ADDR_W-1:0] i_idx,
    output logic      [WIDTH-1:0]  o_best_entry,
    output logic      [ADDR_W-1:0] o_best_idx
);
    import mprq_pkg::*;

    logic signed [PRIO_W-1:0] w_prio;
    logic signed [PRIO_W-1:0] w_best_prio;
    logic                     w_take;

    // A strictly smaller priority wins, so on ties the earlier entry stays.
    assign w_prio      = $signed(i_data[WIDTH-1 -: PRIO_W]);
    assign w_best_prio = $signed(o_best_entry[WIDTH-1 -: PRIO_W]);
    assign w_take      = i_first || (w_prio < w_best_prio);

    always_ff @(posedge i_clk) begin
        if (i_vld && w_take) begin
            o_best_entry <= i_data;
            o_best_idx   <= i_idx;
        end
    end

endmodule

`default_nettype wire

// ===== test/tb_min_priority_request_queue.sv =====
// Testbench for the min-priority request queue top level.
// Depends on mprq_pkg and min_priority_request_queue; predicts every result and
// checks it against the block under directed and random request sequences.
`default_nettype none

module tb_min_priority_request_queue;
    timeunit 1ns;
    timeprecision 1ps;

    import mprq_pkg::*;

    localparam int DEPTH      = 128;
    localparam int TAG_BITS   = 16;
    localparam int RAND_ITEMS = 450;
    // The idle limit allows several times the length of a full pop.
    localparam int POP_CYCLES = 2 * DEPTH + 3;
    localparam int IDLE_LIMIT = 8 * POP_CYCLES;
    localparam logic [TAG_W-1:0] TAG_MASK = TAG_W'((64'd1 << TAG_BITS) - 1);

    // One queued request as the block keeps it.
    typedef struct packed {
        logic signed [PRIO_W-1:0] prio;
        t_kind                    kind;
        logic        [TAG_W-1:0]  tag;
    } t_held_req;

    // Tracks the queue contents and the results still to come from the block.
    class prio_queue_tracker;
        t_held_req held[$];
        t_out_item awaited[$];
        int        mismatches = 0;

        function int level();
            return held.size();
        endfunction

        function int awaited_count();
            return awaited.size();
        endfunction

        function void flag(string msg);
            mismatches++;
            if (mismatches <= 10) begin
                $display("mismatch at %0t: %s", $realtime, msg);
            end
        endfunction

        // Apply one accepted request and queue the result it must produce.
        function void note_request(t_in_item req);
            t_out_item res;
            t_held_req slot;
            int        best;
            res = '0;
            if (req.operation == OP_POP) begin
                if (held.size() == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    // Strict less-than keeps the earliest entry on a tie.
                    best = 0;
                    for (int i = 1; i < held.size(); i++) begin
                        if ($signed(held[i].prio) < $signed(held[best].prio)) begin
                            best = i;
                        end
                    end
                    slot = held[best];
                    held.delete(best);
                    res.status       = ST_POPPED;
                    res.out_priority = slot.prio;
                    res.out_kind     = slot.kind;
                    res.out_name_tag = slot.tag;
                end
            end else if (held.size() >= DEPTH) begin
                res.status = ST_FULL;
            end else begin
                slot.prio = req.priority_req;
                slot.kind = req.request_kind;
                slot.tag  = req.name_tag & TAG_MASK;
                held.push_back(slot);
                res.status = ST_INSERTED;
            end
            res.occupancy = OCC_W'(held.size());
            awaited.push_back(res);
        endfunction

        // Compare one result from the block with the oldest awaited one.
        function void check_result(t_out_item got);
            t_out_item want;
            if (awaited.size() == 0) begin
                flag($sformatf("result with none awaited: status %0d occupancy %0d",
                               got.status, got.occupancy));
                return;
            end
            want = awaited.pop_front();
            if (got.status !== want.status) begin
                flag($sformatf("status: expected %0d, got %0d", want.status, got.status));
            end
            if (got.out_priority !== want.out_priority) begin
                flag($sformatf("out_priority: expected %0d, got %0d",
                               $signed(want.out_priority), $signed(got.out_priority)));
            end
            if (got.out_kind !== want.out_kind) begin
                flag($sformatf("out_kind: expected %0d, got %0d", want.out_kind, got.out_kind));
            end
            if (got.out_name_tag !== want.out_name_tag) begin
                flag($sformatf("out_name_tag: expected %h, got %h",
                               want.out_name_tag, got.out_name_tag));
            end
            if (got.occupancy !== want.occupancy) begin
                flag($sformatf("occupancy: expected %0d, got %0d",
                               want.occupancy, got.occupancy));
            end
        endfunction
    endclass

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      start   = 1'b0;
    t_in_item  i_item  = '0;
    logic      busy;
    logic      o_valid;
    t_out_item o_result;

    prio_queue_tracker tracker = new();
    int idle_cycles = 0;

    min_priority_request_queue #(
        .DEPTH   (DEPTH),
        .TAG_BITS(TAG_BITS)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_item  (i_item),
        .o_valid (o_valid),
        .o_result(o_result)
    );

    // 10 ns clock.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Check results and watch for a stalled handshake.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid) begin
                tracker.check_result(o_result);
            end
            if (o_valid || (start && !busy)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("tb_min_priority_request_queue failed");
                $finish;
            end
        end
    end

    function automatic t_in_item make_request(logic op, logic signed [PRIO_W-1:0] prio,
                                              t_kind kind, logic [TAG_W-1:0] tag);
        t_in_item req;
        req.operation    = op;
        req.priority_req = prio;
        req.request_kind = kind;
        req.name_tag     = tag;
        return req;
    endfunction

    // Hold the item with start high until the block takes it. Start is left high
    // so that the next item of a burst follows without a gap.
    task automatic issue_request(input t_in_item req);
        start  <= 1'b1;
        i_item <= req;
        do @(posedge i_clk); while (busy);
        tracker.note_request(req);
    endtask

    // Stop sending and let every awaited result come back.
    task automatic drain_results();
        start <= 1'b0;
        while (tracker.awaited_count() != 0) @(posedge i_clk);
    endtask

    initial begin
        logic                     do_pop;
        logic signed [PRIO_W-1:0] prio;
        logic        [TAG_W-1:0]  tag;
        logic                     filling;
        int                       fill_target;
        int                       spill;
        int                       burst_left;
        int                       sent;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: empty pops, field extremes, every kind, ties on priority.
        issue_request(make_request(OP_POP, 16'sh1234, KIND_LIST, 16'hABCD));
        issue_request(make_request(OP_INSERT, 16'sh7FFF, KIND_CREATE, 16'h0000));
        issue_request(make_request(OP_INSERT, -16'sh8000, KIND_STOP, 16'hFFFF));
        issue_request(make_request(OP_INSERT, 16'sh0000, KIND_DELETE, 16'h1234));
        issue_request(make_request(OP_INSERT, -16'sh0001, KIND_LIST, 16'h8000));
        issue_request(make_request(OP_INSERT, 16'sh0000, KIND_LIST, 16'h0001));
        issue_request(make_request(OP_INSERT, -16'sh8000, KIND_CREATE, 16'h00AA));
        issue_request(make_request(OP_POP, 16'sh7FFF, KIND_LIST, 16'hFFFF));
        issue_request(make_request(OP_POP, -16'sh8000, KIND_STOP, 16'h5555));
        issue_request(make_request(OP_POP, 16'sh0000, KIND_CREATE, 16'h0000));
        issue_request(make_request(OP_POP, 16'sh2AAA, KIND_DELETE, 16'hAAAA));
        issue_request(make_request(OP_POP, 16'sh0000, KIND_CREATE, 16'h0000));
        issue_request(make_request(OP_POP, 16'sh0000, KIND_CREATE, 16'h0000));
        issue_request(make_request(OP_POP, 16'sh0000, KIND_CREATE, 16'h0000));
        issue_request(make_request(OP_POP, -16'sh0001, KIND_LIST, 16'hFFFF));

        // Pause until the queue has answered everything.
        drain_results();

        // Random part: fill and drain rounds. The first round fills the queue to
        // the top and pushes a few refused inserts; later rounds pick a level.
        filling     = 1'b1;
        fill_target = DEPTH;
        spill       = $urandom_range(1, 3);
        burst_left  = $urandom_range(1, 10);
        sent        = 0;
        while (sent < RAND_ITEMS) begin
            if (filling) begin
                do_pop = ($urandom_range(0, 7) == 0);
            end else begin
                do_pop = ($urandom_range(0, 7) != 0);
            end
            case ($urandom_range(0, 5))
                0: prio = -16'sh8000;
                1: prio = 16'sh7FFF;
                2: prio = PRIO_W'(int'($urandom_range(0, 6)) - 3);
                default: prio = PRIO_W'($urandom_range(0, 65535));
            endcase
            case ($urandom_range(0, 5))
                0: tag = '0;
                1: tag = '1;
                default: tag = TAG_W'($urandom_range(0, 65535));
            endcase
            issue_request(make_request(do_pop ? OP_POP : OP_INSERT, prio,
                                       t_kind'($urandom_range(0, 3)), tag));
            sent++;

            // Switch between filling and draining once the target is reached.
            if (filling) begin
                if (tracker.level() >= fill_target) begin
                    if (spill == 0) begin
                        filling = 1'b0;
                        spill   = $urandom_range(1, 3);
                    end else begin
                        spill--;
                    end
                end
            end else if (tracker.level() == 0) begin
                if (spill == 0) begin
                    filling     = 1'b1;
                    fill_target = ($urandom_range(0, 1) == 0) ? DEPTH
                                                              : $urandom_range(1, 24);
                    spill       = $urandom_range(1, 3);
                end else begin
                    spill--;
                end
            end

            // Bursts of random length, some long, with random gaps between them.
            burst_left--;
            if (burst_left == 0) begin
                start <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
                burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                         : $urandom_range(1, 10);
            end
        end

        // Wait for the last results, then a little longer for stray ones.
        drain_results();
        repeat (POP_CYCLES + 8) @(posedge i_clk);
        if (tracker.mismatches == 0 && tracker.awaited_count() == 0) begin
            $display("tb_min_priority_request_queue passed");
        end else begin
            $display("tb_min_priority_request_queue failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
